// ===== src/ssi_pkg.sv =====
// Package for the segment-segment intersection block: field types and constants.
// No dependencies; all other files refer to it by scoped names.
package ssi_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int OUT_BITS        = 24;
    localparam int PT_FRAC_BITS    = 8;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int PROD_BITS       = 2 * DIFF_BITS;
    localparam int DET_BITS        = PROD_BITS + 1;
    localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic                       hit;
        logic [PARAM_BITS-1:0]      param_along_first;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_seg_hit;

endpackage

// ===== src/ssi_in_if.sv =====
// Input channel interface: valid/ready handshake carrying one segment pair.
// Depends on ssi_pkg.
interface ssi_in_if;
    logic                valid;
    logic                ready;
    ssi_pkg::t_seg_pair  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ssi_out_if.sv =====
// Output channel interface: valid/ready handshake carrying one intersection result.
// Depends on ssi_pkg.
interface ssi_out_if;
    logic               valid;
    logic               ready;
    ssi_pkg::t_seg_hit  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/segment_segment_intersection_top.sv =====
// Segment-segment intersection, fully pipelined.
// Pipeline: PARAM_FRAC_BITS + 6 register stages (22 at defaults).
// Throughput: one item per cycle; the pipeline holds as a whole when the output is stalled.
// Reset: synchronous, active low on i_rst_n; clears all stage valid bits, no data is cleared.
// Depends on ssi_pkg, ssi_in_if, ssi_out_if.
module segment_segment_intersection_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssi_in_if.sink     i_in,
    ssi_out_if.source  o_out
);

    localparam int DB = ssi_pkg::DIFF_BITS;
    localparam int PB = ssi_pkg::PROD_BITS;
    localparam int TB = ssi_pkg::DET_BITS;
    localparam int FB = ssi_pkg::PARAM_FRAC_BITS;
    localparam int QB = ssi_pkg::PARAM_BITS;
    localparam int CB = ssi_pkg::COORD_BITS;
    localparam int OB = ssi_pkg::OUT_BITS;
    localparam int KS = FB - ssi_pkg::PT_FRAC_BITS;  // rounding shift of dx1*s
    localparam int MB = DB + QB + 1;                 // product of dx1 and s
    localparam int SB = MB - KS + 1;                 // shifted product plus carry room
    localparam int XB = SB + 2;                      // point before saturation

    // Whole-pipeline advance: move when the output register is free or being taken.
    logic w_adv;
    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Stage 1: coordinate differences.
    logic                 r_v1;
    logic signed [DB-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_ox, r_oy;
    logic signed [CB-1:0] r_sx1, r_sy1;

    // Stage 2: six products.
    logic                 r_v2;
    logic signed [PB-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;
    logic signed [DB-1:0] r_dx1_2, r_dy1_2;
    logic signed [CB-1:0] r_sx2, r_sy2;

    // Stage 3: determinant and the two numerators.
    logic                 r_v3;
    logic signed [TB-1:0] r_det, r_ns, r_nt;
    logic signed [DB-1:0] r_dx1_3, r_dy1_3;
    logic signed [CB-1:0] r_sx3, r_sy3;

    // Divider stages: index 0 is the normalized compare, 1..FB one quotient bit each.
    logic                 r_dv  [0:FB];
    logic                 r_dh  [0:FB];
    logic                 r_df  [0:FB];
    logic [TB-1:0]        r_dr  [0:FB];
    logic [TB-1:0]        r_dd  [0:FB];
    logic [FB-1:0]        r_dq  [0:FB];
    logic signed [DB-1:0] r_ddx [0:FB];
    logic signed [DB-1:0] r_ddy [0:FB];
    logic signed [CB-1:0] r_dsx [0:FB];
    logic signed [CB-1:0] r_dsy [0:FB];

    // Multiply stage.
    logic                 r_vm, r_hm;
    logic [QB-1:0]        r_sq;
    logic signed [MB-1:0] r_mx, r_my;
    logic signed [CB-1:0] r_sxm, r_sym;

    // Output register.
    logic                 r_fv;
    ssi_pkg::t_seg_hit    r_res;

    // Normalize sign of the determinant and test both parameters against [0,1].
    logic signed [TB-1:0] w_det, w_ns, w_nt;
    logic                 w_hit;
    always_comb begin
        w_det = r_det[TB-1] ? -r_det : r_det;
        w_ns  = r_det[TB-1] ? -r_ns  : r_ns;
        w_nt  = r_det[TB-1] ? -r_nt  : r_nt;
        w_hit = (r_det != '0) && !w_ns[TB-1] && (w_ns <= w_det)
                && !w_nt[TB-1] && (w_nt <= w_det);
    end

    // Final quotient: numerator equal to the determinant gives exactly 1.0.
    logic [QB-1:0] w_sq;
    assign w_sq = r_df[FB] ? QB'(1) << FB : {1'b0, r_dq[FB]};

    // Round dx1*s to the point's fraction, add the start, saturate.
    logic signed [SB-1:0] w_rx, w_ry;
    logic signed [XB-1:0] w_px, w_py, w_lim_hi, w_lim_lo;
    logic signed [OB-1:0] w_cx, w_cy;
    always_comb begin
        w_rx = SB'((r_mx + (MB'(1) <<< (KS - 1))) >>> KS);
        w_ry = SB'((r_my + (MB'(1) <<< (KS - 1))) >>> KS);
        w_px = (XB'(r_sxm) <<< ssi_pkg::PT_FRAC_BITS) + XB'(w_rx);
        w_py = (XB'(r_sym) <<< ssi_pkg::PT_FRAC_BITS) + XB'(w_ry);
        w_lim_hi = XB'({1'b0, {(OB-1){1'b1}}});
        w_lim_lo = -w_lim_hi - XB'(1);
        w_cx = (w_px > w_lim_hi) ? OB'(w_lim_hi) :
               (w_px < w_lim_lo) ? OB'(w_lim_lo) : OB'(w_px);
        w_cy = (w_py > w_lim_hi) ? OB'(w_lim_hi) :
               (w_py < w_lim_lo) ? OB'(w_lim_lo) : OB'(w_py);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vm <= 1'b0;
            r_fv <= 1'b0;
            for (int k = 0; k <= FB; k++) r_dv[k] <= 1'b0;
        end else if (w_adv) begin
            r_v1    <= i_in.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv[0] <= r_v3;
            for (int k = 1; k <= FB; k++) r_dv[k] <= r_dv[k-1];
            r_vm    <= r_dv[FB];
            r_fv    <= r_vm;
        end
    end

    // Datapath; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Stage 1: differences
            r_dx1 <= DB'(i_in.data.first_end_x)    - DB'(i_in.data.first_start_x);
            r_dy1 <= DB'(i_in.data.first_end_y)    - DB'(i_in.data.first_start_y);
            r_dx2 <= DB'(i_in.data.second_end_x)   - DB'(i_in.data.second_start_x);
            r_dy2 <= DB'(i_in.data.second_end_y)   - DB'(i_in.data.second_start_y);
            r_ox  <= DB'(i_in.data.second_start_x) - DB'(i_in.data.first_start_x);
            r_oy  <= DB'(i_in.data.second_start_y) - DB'(i_in.data.first_start_y);
            r_sx1 <= i_in.data.first_start_x;
            r_sy1 <= i_in.data.first_start_y;
            // Stage 2: products
            r_pa    <= PB'(r_dx2) * PB'(r_dy1);
            r_pb    <= PB'(r_dy2) * PB'(r_dx1);
            r_pc    <= PB'(r_dx2) * PB'(r_oy);
            r_pd    <= PB'(r_dy2) * PB'(r_ox);
            r_pe    <= PB'(r_dx1) * PB'(r_oy);
            r_pf    <= PB'(r_dy1) * PB'(r_ox);
            r_dx1_2 <= r_dx1;
            r_dy1_2 <= r_dy1;
            r_sx2   <= r_sx1;
            r_sy2   <= r_sy1;
            // Stage 3: determinant and numerators
            r_det   <= TB'(r_pa) - TB'(r_pb);
            r_ns    <= TB'(r_pc) - TB'(r_pd);
            r_nt    <= TB'(r_pe) - TB'(r_pf);
            r_dx1_3 <= r_dx1_2;
            r_dy1_3 <= r_dy1_2;
            r_sx3   <= r_sx2;
            r_sy3   <= r_sy2;
            // Divider entry
            r_dh[0]  <= w_hit;
            r_df[0]  <= (w_ns == w_det);
            r_dr[0]  <= w_ns;
            r_dd[0]  <= w_det;
            r_dq[0]  <= '0;
            r_ddx[0] <= r_dx1_3;
            r_ddy[0] <= r_dy1_3;
            r_dsx[0] <= r_sx3;
            r_dsy[0] <= r_sy3;
            // One restoring step per stage
            for (int k = 1; k <= FB; k++) begin
                if ({r_dr[k-1][TB-2:0], 1'b0} >= r_dd[k-1]) begin
                    r_dr[k] <= {r_dr[k-1][TB-2:0], 1'b0} - r_dd[k-1];
                    r_dq[k] <= {r_dq[k-1][FB-2:0], 1'b1};
                end else begin
                    r_dr[k] <= {r_dr[k-1][TB-2:0], 1'b0};
                    r_dq[k] <= {r_dq[k-1][FB-2:0], 1'b0};
                end
                r_dh[k]  <= r_dh[k-1];
                r_df[k]  <= r_df[k-1];
                r_dd[k]  <= r_dd[k-1];
                r_ddx[k] <= r_ddx[k-1];
                r_ddy[k] <= r_ddy[k-1];
                r_dsx[k] <= r_dsx[k-1];
                r_dsy[k] <= r_dsy[k-1];
            end
            // Multiply stage
            r_hm  <= r_dh[FB];
            r_sq  <= w_sq;
            r_mx  <= MB'(r_ddx[FB]) * MB'($signed({1'b0, w_sq}));
            r_my  <= MB'(r_ddy[FB]) * MB'($signed({1'b0, w_sq}));
            r_sxm <= r_dsx[FB];
            r_sym <= r_dsy[FB];
            // Output: zero every field on a miss
            r_res.hit               <= r_hm;
            r_res.param_along_first <= r_hm ? r_sq : '0;
            r_res.cross_x           <= r_hm ? w_cx : '0;
            r_res.cross_y           <= r_hm ? w_cy : '0;
        end
    end

    assign o_out.valid = r_fv;
    assign o_out.data  = r_res;

`ifndef SYNTHESIS
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.hit) |-> (o_out.data.param_along_first == '0
            && o_out.data.cross_x == '0 && o_out.data.cross_y == '0))
        else $error("miss result carries nonzero fields");
    a_param_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.hit) |-> (o_out.data.param_along_first <= (QB'(1) << FB)))
        else $error("parameter above 1.0");
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("transfer lost at pipeline entry");
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("stalled result changed");
`endif

endmodule

// ===== verif/tb_segment_segment_intersection_top.sv =====
// Testbench for segment_segment_intersection_top: drives segment pairs, predicts each
// crossing result in a behavioral model and compares every output transfer in order.
// Depends on ssi_pkg, ssi_in_if, ssi_out_if and the block itself.
`timescale 1ns / 1ps

module tb_segment_segment_intersection_top;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ssi_in_if  in_ch ();
    ssi_out_if out_ch ();

    segment_segment_intersection_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    ssi_pkg::t_seg_hit expected_hits[$];
    int       error_count = 0;
    int       idle_count = 0;
    bit       idle_off = 1'b0;     // no random idling on either side
    bit       hold_sink = 1'b0;    // long receiver hold-off request

    // Predict the crossing result for one segment pair.
    function automatic ssi_pkg::t_seg_hit predict_crossing(ssi_pkg::t_seg_pair p);
        ssi_pkg::t_seg_hit r;
        longint fsx, fsy, fex, fey, ssx, ssy, sex, sey;
        longint dx1, dy1, dx2, dy2, ox, oy, det, ns, nt, px, py, rem;
        longint sq;
        r = '0;
        fsx = p.first_start_x;  fsy = p.first_start_y;
        fex = p.first_end_x;    fey = p.first_end_y;
        ssx = p.second_start_x; ssy = p.second_start_y;
        sex = p.second_end_x;   sey = p.second_end_y;
        dx1 = fex - fsx; dy1 = fey - fsy;
        dx2 = sex - ssx; dy2 = sey - ssy;
        ox = ssx - fsx;  oy = ssy - fsy;
        det = dx2 * dy1 - dy2 * dx1;
        ns = dx2 * oy - dy2 * ox;
        nt = dx1 * oy - dy1 * ox;
        if (det == 0) return r;
        if (det < 0) begin
            det = -det; ns = -ns; nt = -nt;
        end
        if (ns < 0 || ns > det || nt < 0 || nt > det) return r;
        // truncated fraction, exact in 64 bits since ns < 2^35
        if (ns >= det) sq = longint'(1) << ssi_pkg::PARAM_FRAC_BITS;
        else sq = (ns <<< ssi_pkg::PARAM_FRAC_BITS) / det;
        rem = ssi_pkg::PARAM_FRAC_BITS - ssi_pkg::PT_FRAC_BITS;
        // floor shift of (v + half) gives round to nearest, ties upward
        px = (fsx <<< ssi_pkg::PT_FRAC_BITS)
             + ((dx1 * sq + (longint'(1) << (rem - 1))) >>> rem);
        py = (fsy <<< ssi_pkg::PT_FRAC_BITS)
             + ((dy1 * sq + (longint'(1) << (rem - 1))) >>> rem);
        if (px > 8388607) px = 8388607;
        if (px < -8388608) px = -8388608;
        if (py > 8388607) py = 8388607;
        if (py < -8388608) py = -8388608;
        r.hit = 1'b1;
        r.param_along_first = sq[ssi_pkg::PARAM_BITS-1:0];
        r.cross_x = px[ssi_pkg::OUT_BITS-1:0];
        r.cross_y = py[ssi_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    // Offer one pair; hold it until the transfer happens. Valid stays high after the
    // transfer so the next pair can follow back to back.
    task automatic send_pair(ssi_pkg::t_seg_pair p);
        while (!idle_off && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        expected_hits.push_back(predict_crossing(p));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic ssi_pkg::t_seg_pair random_pair();
        ssi_pkg::t_seg_pair p;
        int        span;
        p = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(3))
            0: ; // full range noise
            1, 2: begin
                // small coordinates make crossings likely
                span = (2 << $urandom_range(10));
                p.first_start_x  = 16'($signed($urandom_range(2*span)) - span);
                p.first_start_y  = 16'($signed($urandom_range(2*span)) - span);
                p.first_end_x    = 16'($signed($urandom_range(2*span)) - span);
                p.first_end_y    = 16'($signed($urandom_range(2*span)) - span);
                p.second_start_x = 16'($signed($urandom_range(2*span)) - span);
                p.second_start_y = 16'($signed($urandom_range(2*span)) - span);
                p.second_end_x   = 16'($signed($urandom_range(2*span)) - span);
                p.second_end_y   = 16'($signed($urandom_range(2*span)) - span);
            end
            default: begin
                // build a crossing: second segment runs through a point on the first
                p.second_start_x = p.first_start_x + (p.first_end_x - p.first_start_x) / 2;
                p.second_start_y = p.first_start_y + (p.first_end_y - p.first_start_y) / 2;
                p.second_end_x   = 16'(p.second_start_x
                                       + $signed(16'($urandom_range(255))) - 128);
                p.second_end_y   = 16'(p.second_start_y
                                       + $signed(16'($urandom_range(255))) - 128);
            end
        endcase
        return p;
    endfunction

    // Check each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_hits.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                ssi_pkg::t_seg_hit e;
                e = expected_hits.pop_front();
                if (out_ch.data.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, out_ch.data.hit);
                    error_count++;
                end
                if (out_ch.data.param_along_first !== e.param_along_first) begin
                    $error("param_along_first exp %0d got %0d",
                           e.param_along_first, out_ch.data.param_along_first);
                    error_count++;
                end
                if (out_ch.data.cross_x !== e.cross_x) begin
                    $error("cross_x exp %0d got %0d", e.cross_x, out_ch.data.cross_x);
                    error_count++;
                end
                if (out_ch.data.cross_y !== e.cross_y) begin
                    $error("cross_y exp %0d got %0d", e.cross_y, out_ch.data.cross_y);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_sink && hold_left == 0) begin
            hold_left = 200;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left = 0;
            out_ch.ready <= idle_off || ($urandom_range(99) >= 8);
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (expected_hits.size() == 0 && !in_ch.valid)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        ssi_pkg::t_seg_pair p;
        // plain X crossing in the middle
        p = '{-16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd0, -16'sd10, 16'sd0, 16'sd10};
        send_pair(p);
        // parallel: no hit
        p = '{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd5, 16'sd10, 16'sd5};
        send_pair(p);
        // collinear overlap, still det zero
        p = '{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0, 16'sd20, 16'sd0};
        send_pair(p);
        // degenerate first segment (a point)
        p = '{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd9, 16'sd9};
        send_pair(p);
        // touching at endpoints: s = 0 and s = 1
        p = '{16'sd0, 16'sd0, 16'sd8, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd8};
        send_pair(p);
        p = '{16'sd0, 16'sd0, 16'sd8, 16'sd0, 16'sd8, -16'sd4, 16'sd8, 16'sd4};
        send_pair(p);
        // miss beyond the end of the first segment
        p = '{16'sd0, 16'sd0, 16'sd8, 16'sd0, 16'sd9, -16'sd4, 16'sd9, 16'sd4};
        send_pair(p);
        // miss beyond the end of the second segment
        p = '{16'sd0, 16'sd0, 16'sd8, 16'sd0, 16'sd4, 16'sd1, 16'sd4, 16'sd5};
        send_pair(p);
        // negative determinant crossing, fractional s
        p = '{16'sd0, 16'sd0, 16'sd3, 16'sd7, 16'sd3, 16'sd0, 16'sd0, 16'sd5};
        send_pair(p);
        // full-range diagonals crossing at (-0.5, -0.5), next to the origin
        p = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
              -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768};
        send_pair(p);
        // extreme corners, endpoints shared
        p = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
              16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768};
        send_pair(p);
        p = '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
              -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767};
        send_pair(p);
        // all ones and all zeros
        send_pair('1);
        send_pair('0);
        // short segments crossing half-way: s = 1/2, point (0.5, -0.5)
        p = '{16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd0, -16'sd1, 16'sd3, 16'sd2};
        send_pair(p);
    endtask

    task automatic test_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    // Burst with no idling while the receiver is held off.
    task automatic test_backpressure();
        idle_off = 1'b1;
        hold_sink = 1'b1;
        // keep the request up until the receiver has surely seen it
        @(posedge i_clk);
        @(posedge i_clk);
        hold_sink = 1'b0;
        test_random(100);
        idle_off = 1'b0;
    endtask

    initial begin
        int drain;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        test_backpressure();
        test_random(400);
        in_ch.valid <= 1'b0;

        drain = 0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
